>>> rtl/prhr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prhr_pkg: shared types and constants of the pre-roll history ring
// Ring geometry, item kind codes, internal operation codes and the beat
// structures that pass between the front end, the back end and the result
// queue.
// ---------------------------------------------------------------------------
package prhr_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 65536;
  localparam int AW         = $clog2(RING_DEPTH);
  localparam int HW         = AW + 1;

  // Field widths
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int KIND_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int SEQ_W      = 64;
  localparam int SEQ_CNT_W  = $clog2(SEQ_W + 1);

  // Saturating counters only need to tell apart values up to 2^CFG_W
  localparam int SAT_W      = CFG_W + 1;
  localparam logic [SAT_W-1:0] SAT_MAX = {1'b1, {CFG_W{1'b0}}};

  // Result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREROLL = 1'd1;

  localparam logic [CFG_W-1:0] HIST_RESET    = 17'd65536;
  localparam logic [CFG_W-1:0] PREROLL_RESET = 17'd16000;

  // Item kinds on the input port
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MARK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PULL   = 3'd4;

  // Internal operations after classification
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK  = 3'd2;
  localparam logic [OP_W-1:0] OP_START = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd4;
  localparam logic [OP_W-1:0] OP_PULL  = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              running;
    logic [CFG_W-1:0]  replay_bytes;
    logic              overrun;
  } res_t;

  // Map a written history length onto the usable range 1..RING_DEPTH.
  function automatic logic [HW-1:0] clamp_hist(input logic [CFG_W-1:0] v);
    logic [HW-1:0] r;
    if (v == '0) begin
      r = HW'(1);
    end else if (int'(v) > RING_DEPTH) begin
      r = HW'(RING_DEPTH);
    end else begin
      r = HW'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/prhr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prhr_ram: generic single-port RAM
// One access per cycle, write or read, with the read data registered.
// ---------------------------------------------------------------------------
module prhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> rtl/prhr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prhr_front: input acceptance and classification
// Decodes each input beat into an internal operation and holds it in a
// two-entry command queue until the back end takes it.
// ---------------------------------------------------------------------------
module prhr_front
  import prhr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [BYTE_W-1:0] sample_byte,
  input  wire logic              hold,
  output logic                   full,
  output logic                   cmd_valid,
  output cmd_t                   cmd,
  input  wire logic              take
);

  cmd_t       q [2];
  cmd_t       dec;
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       accept;

  always_comb begin
    dec.data = sample_byte;
    case (kind)
      KIND_SAMPLE: dec.op = OP_WRITE;
      KIND_MARK:   dec.op = OP_MARK;
      KIND_START:  dec.op = OP_START;
      KIND_STOP:   dec.op = OP_STOP;
      KIND_PULL:   dec.op = OP_PULL;
      default:     dec.op = OP_NONE;
    endcase
  end

  assign full      = (count == 2'd2) | hold;
  assign accept    = push & ~full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, accept} - {1'b0, take};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= dec;
    end
  end

endmodule
`default_nettype wire

>>> rtl/prhr_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prhr_mod: serial remainder unit
// Restoring remainder of the 64-bit write sequence by the history length,
// one dividend bit per cycle, used to realign the write position after the
// history length is changed.
// ---------------------------------------------------------------------------
module prhr_mod
  import prhr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SEQ_W-1:0] dividend,
  input  wire logic [HW-1:0]    divisor,
  output logic                  busy,
  output logic                  done,
  output logic      [HW-1:0]    result
);

  logic [SEQ_CNT_W-1:0] cnt;
  logic [SEQ_W-1:0]     dvd;
  logic [HW-1:0]        rem;
  logic [HW:0]          shifted;
  logic [HW-1:0]        rem_next;

  // The remainder stays below the divisor, so the shifted value is below
  // twice the divisor and one conditional subtract suffices.
  always_comb begin
    shifted = {rem, dvd[SEQ_W-1]};
    if (shifted >= {1'b0, divisor}) begin
      rem_next = HW'(shifted - {1'b0, divisor});
    end else begin
      rem_next = HW'(shifted);
    end
  end

  assign busy   = (cnt != '0);
  assign done   = (cnt == SEQ_CNT_W'(1));
  assign result = rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= SEQ_CNT_W'(SEQ_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[SEQ_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/prhr_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prhr_outq: result queue
// Small queue of finished results in front of the result port; its fill
// level gives the back end its credit.
// ---------------------------------------------------------------------------
module prhr_outq
  import prhr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire res_t             wr_res,
  input  wire logic             pop,
  output logic                  empty,
  output res_t                  head,
  output logic      [OUTQ_AW:0] level
);

  res_t               q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] rd_ptr;
  logic [OUTQ_AW-1:0] wr_ptr;
  logic               rd;

  assign empty = (level == '0);
  assign rd    = pop & ~empty;
  assign head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + {{OUTQ_AW{1'b0}}, wr} - {{OUTQ_AW{1'b0}}, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_ptr] <= wr_res;
    end
  end

endmodule
`default_nettype wire

>>> rtl/prhr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prhr_back: operation execution
// Holds the sequence state, writes and reads the history ring, and forms
// one result per operation, registered in the stage after the ring access.
// ---------------------------------------------------------------------------
module prhr_back
  import prhr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  input  wire cmd_t             cmd,
  output logic                  take,
  input  wire logic [HW-1:0]    hist,
  input  wire logic [CFG_W-1:0] pre_roll,
  input  wire logic             realign,
  output logic                  realign_busy,
  input  wire logic [OUTQ_AW:0] outq_level,
  output logic                  res_wr,
  output res_t                  res
);

  // Architectural state
  logic [SEQ_W-1:0] ws;
  logic [AW-1:0]    wp;
  logic [SAT_W-1:0] ws_sat;
  logic [SAT_W-1:0] mark_sat;
  logic [SAT_W-1:0] dist_sat;
  logic             mark_valid;
  logic             run;
  logic             ovr;
  logic [HW-1:0]    unread;
  logic [CFG_W-1:0] replay;

  logic [AW-1:0]    wp_next;
  logic [SAT_W-1:0] mark_sat_next;
  logic [SAT_W-1:0] dist_sat_next;
  logic             mark_valid_next;
  logic             run_next;
  logic             ovr_next;
  logic [HW-1:0]    unread_next;
  logic [CFG_W-1:0] replay_next;

  // Helpers
  logic [AW-1:0]    wp_inc;
  logic [HW-1:0]    avail;
  logic [HW-1:0]    rd_lin;
  logic [AW-1:0]    rd_addr;
  logic [SAT_W:0]   base;
  logic [HW-1:0]    start_cnt;
  logic             credit;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [BYTE_W-1:0] ram_rdata;
  logic             is_write;
  logic             is_pull_hit;

  // Stage after the ring access
  logic             p_valid;
  logic             p_pull;
  res_t             p_res;

  logic             mod_done;
  logic [HW-1:0]    mod_rem;

  function automatic logic [SAT_W-1:0] sat_inc(input logic [SAT_W-1:0] v);
    return (v == SAT_MAX) ? v : v + 1'b1;
  endfunction

  // A slot in the result queue is reserved for the operation in flight.
  assign credit = (int'(outq_level) + int'(p_valid)) < OUTQ_DEPTH;
  assign take   = cmd_valid & credit & ~realign_busy;

  always_comb begin
    wp_inc = ({1'b0, wp} + HW'(1) == hist) ? '0 : wp + 1'b1;

    // Unread bytes after a catch-up, and the ring slot of the oldest one
    avail  = (unread > hist) ? hist : unread;
    if ({1'b0, wp} >= avail) begin
      rd_lin = {1'b0, wp} - avail;
    end else begin
      rd_lin = {1'b0, wp} + hist - avail;
    end
    rd_addr = rd_lin[AW-1:0];

    // Replay length of a start with a marker held
    if (mark_sat > {1'b0, pre_roll}) begin
      base = {1'b0, dist_sat} + {2'b00, pre_roll};
    end else begin
      base = {1'b0, ws_sat};
    end
    if (!mark_valid) begin
      start_cnt = '0;
    end else if (base > {{(SAT_W + 1 - HW){1'b0}}, hist}) begin
      start_cnt = hist;
    end else begin
      start_cnt = HW'(base);
    end
  end

  always_comb begin
    wp_next         = wp;
    mark_sat_next   = mark_sat;
    dist_sat_next   = dist_sat;
    mark_valid_next = mark_valid;
    run_next        = run;
    ovr_next        = ovr;
    unread_next     = unread;
    replay_next     = replay;
    is_write        = 1'b0;
    is_pull_hit     = 1'b0;

    if (take) begin
      case (cmd.op)
        OP_WRITE: begin
          is_write      = 1'b1;
          wp_next       = wp_inc;
          dist_sat_next = sat_inc(dist_sat);
          if (run) begin
            if (unread + 1'b1 > hist) begin
              unread_next = hist;
              ovr_next    = 1'b1;
            end else begin
              unread_next = unread + 1'b1;
            end
          end
        end
        OP_MARK: begin
          mark_sat_next   = ws_sat;
          dist_sat_next   = '0;
          mark_valid_next = 1'b1;
        end
        OP_START: begin
          if (!run) begin
            unread_next     = start_cnt;
            replay_next     = CFG_W'(start_cnt);
            run_next        = 1'b1;
            mark_valid_next = 1'b0;
            ovr_next        = 1'b0;
          end
        end
        OP_STOP: begin
          if (run) begin
            run_next        = 1'b0;
            mark_valid_next = 1'b0;
          end
        end
        OP_PULL: begin
          if (run) begin
            if (unread > hist) begin
              ovr_next = 1'b1;
            end
            if (avail != '0) begin
              is_pull_hit = 1'b1;
              unread_next = avail - 1'b1;
            end else begin
              unread_next = avail;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ram_we   = is_write;
  assign ram_addr = is_write ? wp : rd_addr;

  prhr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(cmd.data),
    .rdata(ram_rdata)
  );

  prhr_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (realign),
    .dividend(ws),
    .divisor (hist),
    .busy    (realign_busy),
    .done    (mod_done),
    .result  (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ws         <= '0;
      wp         <= '0;
      ws_sat     <= '0;
      mark_sat   <= '0;
      dist_sat   <= '0;
      mark_valid <= 1'b0;
      run        <= 1'b0;
      ovr        <= 1'b0;
      unread     <= '0;
      replay     <= '0;
      p_valid    <= 1'b0;
      p_pull     <= 1'b0;
    end else begin
      if (is_write) begin
        ws     <= ws + 1'b1;
        ws_sat <= sat_inc(ws_sat);
      end
      if (mod_done) begin
        wp <= mod_rem[AW-1:0];
      end else begin
        wp <= wp_next;
      end
      mark_sat   <= mark_sat_next;
      dist_sat   <= dist_sat_next;
      mark_valid <= mark_valid_next;
      run        <= run_next;
      ovr        <= ovr_next;
      unread     <= unread_next;
      replay     <= replay_next;
      p_valid    <= take;
      p_pull     <= is_pull_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_res.out_byte     <= '0;
      p_res.out_valid    <= is_pull_hit;
      p_res.running      <= run_next;
      p_res.replay_bytes <= replay_next;
      p_res.overrun      <= ovr_next;
    end
  end

  always_comb begin
    res          = p_res;
    res.out_byte = p_pull ? ram_rdata : '0;
  end

  assign res_wr = p_valid;

endmodule
`default_nettype wire

>>> rtl/preroll_history_ring_replay.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// preroll_history_ring_replay: pre-trigger capture ring with replay
// Keeps a circular history of audio bytes and replays it from shortly
// before a wake marker, running straight on into live data.
// ---------------------------------------------------------------------------
// Input beats are taken when push is high and full is low; kind selects a
// sample byte, a wake marker, start, stop or a pull of one byte. Every input
// beat yields one result beat, shown while empty is low and taken when pop
// is high: the pulled byte (zero when out_valid is low) and the running,
// replay_bytes and overrun status as they stand after that beat. cfg_we
// writes cfg_data into register cfg_index (0 history length, 1 pre-roll)
// with no wait; the user must write it only while the block holds no
// unfinished beat; the block does not enforce it. One beat per cycle is
// sustained both ways while no realignment runs and results are popped.
// A result passes the command queue and the ring access stage, then goes
// into the result queue. Writing the history length realigns the write
// position with a serial remainder over the 64-bit sequence count; full
// is high in the write cycle and for the 64 remainder steps after it.
// Reset empties both queues, clears all counters, stops output and loads a
// history of 65536 and a pre-roll of 16000 bytes; the ring is not cleared.
// A stalled receiver fills the result queue, the back end stops taking
// commands, and full rises once the command queue holds two beats.
// ---------------------------------------------------------------------------
module preroll_history_ring_replay
  import prhr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [KIND_W-1:0]    kind,
  input  wire logic [BYTE_W-1:0]    sample_byte,
  output logic                      empty,
  input  wire logic                 pop,
  output logic      [BYTE_W-1:0]    out_byte,
  output logic                      out_valid,
  output logic                      running,
  output logic      [CFG_W-1:0]     replay_bytes,
  output logic                      overrun,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // Configuration, the history length is kept already clamped.
  logic [HW-1:0]    hist;
  logic [CFG_W-1:0] pre_roll;
  logic             hist_wr;

  logic             realign_busy;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             take;
  logic             res_wr;
  res_t             res;
  res_t             head;
  logic [OUTQ_AW:0] outq_level;

  assign hist_wr = cfg_we & (cfg_index == CFG_HISTORY);

  always_ff @(posedge clk) begin
    if (rst) begin
      hist     <= clamp_hist(HIST_RESET);
      pre_roll <= PREROLL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HISTORY: hist     <= clamp_hist(cfg_data);
        CFG_PREROLL: pre_roll <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end holds off new beats while the write position is being
  // realigned to a new history length.
  prhr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .kind       (kind),
    .sample_byte(sample_byte),
    .hold       (realign_busy | hist_wr),
    .full       (full),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .take       (take)
  );

  prhr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .take        (take),
    .hist        (hist),
    .pre_roll    (pre_roll),
    .realign     (hist_wr),
    .realign_busy(realign_busy),
    .outq_level  (outq_level),
    .res_wr      (res_wr),
    .res         (res)
  );

  prhr_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_wr),
    .wr_res(res),
    .pop   (pop),
    .empty (empty),
    .head  (head),
    .level (outq_level)
  );

  assign out_byte     = head.out_byte;
  assign out_valid    = head.out_valid;
  assign running      = head.running;
  assign replay_bytes = head.replay_bytes;
  assign overrun      = head.overrun;

endmodule
`default_nettype wire

>>> rtl/prhr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prhr_checker: port-level checks of the pre-roll history ring
// Watches the top-level ports only and is bound to the top level below.
// ---------------------------------------------------------------------------
module prhr_checker
  import prhr_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 push,
  input wire logic                 full,
  input wire logic [KIND_W-1:0]    kind,
  input wire logic [BYTE_W-1:0]    sample_byte,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire logic [BYTE_W-1:0]    out_byte,
  input wire logic                 out_valid,
  input wire logic                 running,
  input wire logic [CFG_W-1:0]     replay_bytes,
  input wire logic                 overrun,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [CFG_W-1:0]     cfg_data
);

  // A delivered byte only comes from a running capture.
  a_valid_needs_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_valid) |-> running)
    else $error("byte delivered while stopped");

  // A result without a byte carries a zero byte.
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_valid) |-> (out_byte == '0))
    else $error("non-zero byte without out_valid");

  // A replay never exceeds the ring.
  a_replay_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (int'(replay_bytes) <= RING_DEPTH))
    else $error("replay length beyond ring depth");

  // A waiting result stays put until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_valid)
                          && $stable(running) && $stable(replay_bytes)
                          && $stable(overrun)))
    else $error("waiting result changed");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result present after reset");

endmodule

bind preroll_history_ring_replay prhr_checker u_prhr_checker (.*);
`default_nettype wire
